@@ src/rle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg
// Microcode words, step addresses and datapath codes of the run/literal
// encoder sequencer.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int unsigned STEP_W = 5;

  // next-step modes
  localparam logic [2:0] SEQ_NEXT     = 3'd0;
  localparam logic [2:0] SEQ_JUMP     = 3'd1;
  localparam logic [2:0] SEQ_CALL     = 3'd2;
  localparam logic [2:0] SEQ_RET      = 3'd3;
  localparam logic [2:0] SEQ_DISPATCH = 3'd4;
  localparam logic [2:0] SEQ_END      = 3'd5;

  // jump conditions
  localparam logic [1:0] COND_ALWAYS      = 2'd0;
  localparam logic [1:0] COND_RUN_ZERO    = 2'd1;
  localparam logic [1:0] COND_LIT_NONZERO = 2'd2;
  localparam logic [1:0] COND_MORE        = 2'd3;

  // datapath operations
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_PUSH   = 4'd1;
  localparam logic [3:0] OP_STORE  = 4'd2;
  localparam logic [3:0] OP_RUNINC = 4'd3;
  localparam logic [3:0] OP_RUNCLR = 4'd4;
  localparam logic [3:0] OP_DEC2   = 4'd5;
  localparam logic [3:0] OP_SETRUN = 4'd6;
  localparam logic [3:0] OP_RESET  = 4'd7;
  localparam logic [3:0] OP_IDX0   = 4'd8;
  localparam logic [3:0] OP_IDXINC = 4'd9;
  localparam logic [3:0] OP_LITCLR = 4'd10;

  // byte sources for the packer
  localparam logic [2:0] EMIT_NONE    = 3'd0;
  localparam logic [2:0] EMIT_LITHDR  = 3'd1;
  localparam logic [2:0] EMIT_LITDATA = 3'd2;
  localparam logic [2:0] EMIT_RUNHDR  = 3'd3;
  localparam logic [2:0] EMIT_RUNVAL  = 3'd4;

  // program addresses
  localparam logic [STEP_W-1:0] STEP_IDLE        = 5'd0;
  localparam logic [STEP_W-1:0] STEP_FULL        = 5'd1;
  localparam logic [STEP_W-1:0] STEP_STORE       = 5'd2;
  localparam logic [STEP_W-1:0] STEP_RUNINC      = 5'd3;
  localparam logic [STEP_W-1:0] STEP_BREAK       = 5'd4;
  localparam logic [STEP_W-1:0] STEP_BREAK_VAL   = 5'd5;
  localparam logic [STEP_W-1:0] STEP_MATCH       = 5'd6;
  localparam logic [STEP_W-1:0] STEP_MATCH_FLUSH = 5'd7;
  localparam logic [STEP_W-1:0] STEP_MATCH_RUN   = 5'd8;
  localparam logic [STEP_W-1:0] STEP_FIN         = 5'd9;
  localparam logic [STEP_W-1:0] STEP_FIN_HDR     = 5'd10;
  localparam logic [STEP_W-1:0] STEP_FIN_VAL     = 5'd11;
  localparam logic [STEP_W-1:0] STEP_FIN_LIT     = 5'd12;
  localparam logic [STEP_W-1:0] STEP_FIN_RESET   = 5'd13;
  localparam logic [STEP_W-1:0] STEP_LIT         = 5'd14;
  localparam logic [STEP_W-1:0] STEP_LIT_DATA    = 5'd15;
  localparam logic [STEP_W-1:0] STEP_LIT_DONE    = 5'd16;

  localparam logic [7:0] RUN_FLAG    = 8'h80;
  localparam int unsigned RUN_START  = 3;
  localparam logic [1:0] WARMUP_INIT = 2'd2;

  typedef struct packed {
    logic [2:0]        seq;
    logic [1:0]        cond;
    logic [3:0]        op;
    logic [2:0]        emit;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t cw(logic [2:0] seq, logic [1:0] cond, logic [3:0] op,
                               logic [2:0] emit, logic [STEP_W-1:0] target);
    ctrl_t w;
    w.seq    = seq;
    w.cond   = cond;
    w.op     = op;
    w.emit   = emit;
    w.target = target;
    return w;
  endfunction

  // control store
  function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      STEP_IDLE:        w = cw(SEQ_DISPATCH, COND_ALWAYS, OP_PUSH, EMIT_NONE, STEP_IDLE);
      STEP_FULL:        w = cw(SEQ_CALL, COND_ALWAYS, OP_NONE, EMIT_NONE, STEP_LIT);
      STEP_STORE:       w = cw(SEQ_END, COND_ALWAYS, OP_STORE, EMIT_NONE, STEP_IDLE);
      STEP_RUNINC:      w = cw(SEQ_END, COND_ALWAYS, OP_RUNINC, EMIT_NONE, STEP_IDLE);
      STEP_BREAK:       w = cw(SEQ_NEXT, COND_ALWAYS, OP_NONE, EMIT_RUNHDR, STEP_IDLE);
      STEP_BREAK_VAL:   w = cw(SEQ_JUMP, COND_ALWAYS, OP_RUNCLR, EMIT_RUNVAL, STEP_STORE);
      STEP_MATCH:       w = cw(SEQ_NEXT, COND_ALWAYS, OP_DEC2, EMIT_NONE, STEP_IDLE);
      STEP_MATCH_FLUSH: w = cw(SEQ_CALL, COND_LIT_NONZERO, OP_NONE, EMIT_NONE, STEP_LIT);
      STEP_MATCH_RUN:   w = cw(SEQ_END, COND_ALWAYS, OP_SETRUN, EMIT_NONE, STEP_IDLE);
      STEP_FIN:         w = cw(SEQ_JUMP, COND_RUN_ZERO, OP_NONE, EMIT_NONE, STEP_FIN_LIT);
      STEP_FIN_HDR:     w = cw(SEQ_NEXT, COND_ALWAYS, OP_NONE, EMIT_RUNHDR, STEP_IDLE);
      STEP_FIN_VAL:     w = cw(SEQ_NEXT, COND_ALWAYS, OP_RUNCLR, EMIT_RUNVAL, STEP_IDLE);
      STEP_FIN_LIT:     w = cw(SEQ_CALL, COND_LIT_NONZERO, OP_NONE, EMIT_NONE, STEP_LIT);
      STEP_FIN_RESET:   w = cw(SEQ_JUMP, COND_ALWAYS, OP_RESET, EMIT_NONE, STEP_IDLE);
      STEP_LIT:         w = cw(SEQ_NEXT, COND_ALWAYS, OP_IDX0, EMIT_LITHDR, STEP_IDLE);
      STEP_LIT_DATA:    w = cw(SEQ_JUMP, COND_MORE, OP_IDXINC, EMIT_LITDATA, STEP_LIT_DATA);
      STEP_LIT_DONE:    w = cw(SEQ_RET, COND_ALWAYS, OP_LITCLR, EMIT_NONE, STEP_IDLE);
      default:          w = cw(SEQ_JUMP, COND_ALWAYS, OP_NONE, EMIT_NONE, STEP_IDLE);
    endcase
    return w;
  endfunction

endpackage

@@ src/rle_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 127
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/rle_run_literal_encoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_run_literal_encoder_unit
// Run/literal byte encoder driven by a microcoded sequencer; encoded bytes
// are packed into words, first byte lowest.
//
// channel  direction  handshake                payload
// byte     in         byte_valid / byte_ready  data_byte, final_byte
// word     out        word_valid / word_ready  out_word, out_count,
//                                              burst_last, stream_end
//
// a byte that is stored, or extends a run, is accepted in idle and then takes the store or run-increment step
// a literal flush emits the count, then one stored byte per cycle while the output word is not held,
// through the single read port of the literal RAM
// a run flush emits header then value; a burst's last word is pushed in the first unstalled idle cycle
// sync reset clears counters and sequencer; the literal RAM needs no clearing
// a held output word stalls the sequencer on the step that needs to push
// ----------------------------------------------------------------------------
module rle_run_literal_encoder_unit
  import rle_pkg::*;
#(
  parameter int unsigned MAX_BLOCK = 127,
  parameter int unsigned OUT_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        word_valid,
  input  logic        word_ready,
  output logic [31:0] out_word,
  output logic [2:0]  out_count,
  output logic        burst_last,
  output logic        stream_end
);

  localparam int unsigned AW    = $clog2(MAX_BLOCK);
  localparam int unsigned CW    = $clog2(MAX_BLOCK + 1);
  localparam int unsigned CMPW  = CW + 1;
  localparam int unsigned ACC_W = 8 * OUT_BYTES;
  localparam int unsigned CNTW  = $clog2(OUT_BYTES + 1);

  // sequencer
  logic [STEP_W-1:0] pc, pc_next, link, link_next, dispatch_step;
  ctrl_t             ctl;
  logic              cond_true, stall, advance, accept;

  // encoder state
  logic [CW-1:0] lit_count, run_count;
  logic [7:0]    run_value, last1, last2, data_r;
  logic [1:0]    warm;
  logic          fin_r;
  logic [AW-1:0] idx, idx_next;
  logic [7:0]    rd_data;
  logic          more;

  // packer
  logic [ACC_W-1:0]    acc;
  logic [ACC_W+31:0]   acc_ext;
  logic [CNTW-1:0]     acc_cnt;
  logic [7:0]          emit_byte;
  logic                emitting, need_push, push, end_push;

  assign ctl = ucode(pc);

  assign emitting  = (ctl.emit != EMIT_NONE);
  assign end_push  = (ctl.op == OP_PUSH) && (acc_cnt != '0);
  assign need_push = (emitting && (acc_cnt == CNTW'(OUT_BYTES))) || end_push;
  assign stall     = need_push && word_valid && !word_ready;
  assign advance   = !stall;
  assign push      = advance && need_push;

  assign byte_ready = (pc == STEP_IDLE) && !stall;
  assign accept     = byte_valid && byte_ready;

  assign more = (CMPW'(idx) + CMPW'(1)) < CMPW'(lit_count);

  always_comb begin
    case (ctl.cond)
      COND_ALWAYS:      cond_true = 1'b1;
      COND_RUN_ZERO:    cond_true = (run_count == '0);
      COND_LIT_NONZERO: cond_true = (lit_count != '0);
      COND_MORE:        cond_true = more;
      default:          cond_true = 1'b0;
    endcase
  end

  // dispatch map on the live input byte
  always_comb begin
    if (warm != 2'd0) begin
      dispatch_step = STEP_STORE;
    end else if (lit_count != '0) begin
      if ((lit_count >= CW'(2)) && (data_byte == last1) && (data_byte == last2)) begin
        dispatch_step = STEP_MATCH;
      end else if (lit_count >= CW'(MAX_BLOCK)) begin
        dispatch_step = STEP_FULL;
      end else begin
        dispatch_step = STEP_STORE;
      end
    end else if ((data_byte == run_value) && (run_count < CW'(MAX_BLOCK))) begin
      dispatch_step = STEP_RUNINC;
    end else begin
      dispatch_step = STEP_BREAK;
    end
  end

  always_comb begin
    pc_next   = pc;
    link_next = link;
    if (advance) begin
      case (ctl.seq)
        SEQ_NEXT: pc_next = pc + STEP_W'(1);
        SEQ_JUMP: pc_next = cond_true ? ctl.target : pc + STEP_W'(1);
        SEQ_CALL: begin
          if (cond_true) begin
            pc_next   = ctl.target;
            link_next = pc + STEP_W'(1);
          end else begin
            pc_next = pc + STEP_W'(1);
          end
        end
        SEQ_RET: pc_next = link;
        SEQ_DISPATCH: begin
          if (accept) begin
            pc_next = dispatch_step;
          end
        end
        SEQ_END: pc_next = fin_r ? STEP_FIN : STEP_IDLE;
        default: pc_next = STEP_IDLE;
      endcase
    end
  end

  always_comb begin
    idx_next = idx;
    if (advance) begin
      case (ctl.op)
        OP_IDX0:   idx_next = '0;
        OP_IDXINC: idx_next = idx + AW'(1);
        default:   idx_next = idx;
      endcase
    end
  end

  always_comb begin
    case (ctl.emit)
      EMIT_LITHDR:  emit_byte = 8'(lit_count);
      EMIT_LITDATA: emit_byte = rd_data;
      EMIT_RUNHDR:  emit_byte = RUN_FLAG | 8'(run_count);
      EMIT_RUNVAL:  emit_byte = run_value;
      default:      emit_byte = 8'h00;
    endcase
  end

  rle_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BLOCK)
  ) u_lit_ram (
    .clk  (clk),
    .we   (advance && (ctl.op == OP_STORE)),
    .waddr(lit_count[AW-1:0]),
    .wdata(data_r),
    .raddr(idx_next),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= STEP_IDLE;
      link      <= STEP_IDLE;
      idx       <= '0;
      lit_count <= '0;
      run_count <= '0;
      run_value <= 8'h00;
      warm      <= WARMUP_INIT;
    end else begin
      pc   <= pc_next;
      link <= link_next;
      idx  <= idx_next;
      if (advance) begin
        case (ctl.op)
          OP_STORE: begin
            lit_count <= lit_count + CW'(1);
            if (warm != 2'd0) begin
              warm <= warm - 2'd1;
            end
          end
          OP_RUNINC: run_count <= run_count + CW'(1);
          OP_RUNCLR: run_count <= '0;
          OP_DEC2:   lit_count <= lit_count - CW'(2);
          OP_SETRUN: begin
            run_value <= data_r;
            run_count <= CW'(RUN_START);
          end
          OP_RESET: begin
            lit_count <= '0;
            run_count <= '0;
            run_value <= 8'h00;
            warm      <= WARMUP_INIT;
          end
          OP_LITCLR: lit_count <= '0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= data_byte;
      fin_r  <= final_byte;
    end
    if (advance && (ctl.op == OP_STORE)) begin
      last2 <= last1;
      last1 <= data_r;
    end
  end

  // word packer and output register
  assign acc_ext = {32'd0, acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_cnt    <= '0;
      word_valid <= 1'b0;
    end else begin
      if (push) begin
        word_valid <= 1'b1;
      end else if (word_ready) begin
        word_valid <= 1'b0;
      end
      if (advance && emitting) begin
        if ((acc_cnt == '0) || (acc_cnt == CNTW'(OUT_BYTES))) begin
          acc_cnt <= CNTW'(1);
        end else begin
          acc_cnt <= acc_cnt + CNTW'(1);
        end
      end else if (push) begin
        acc_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emitting) begin
      if ((acc_cnt == '0) || (acc_cnt == CNTW'(OUT_BYTES))) begin
        acc <= ACC_W'(emit_byte);
      end else begin
        acc <= acc | (ACC_W'(emit_byte) << {acc_cnt, 3'b000});
      end
    end
    if (push) begin
      out_word   <= acc_ext[31:0];
      out_count  <= 3'(acc_cnt);
      burst_last <= end_push;
      stream_end <= end_push && fin_r;
    end
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (pc != STEP_IDLE))
    else $error("sequencer stayed idle after a transaction");

  a_one_mode: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_IDLE) |-> ((run_count == '0) || (lit_count == '0)))
    else $error("run and literals pending together");

  a_run_min: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_IDLE) |-> ((run_count == '0) || (run_count >= CW'(RUN_START))))
    else $error("run shorter than minimum");

  a_lit_max: assert property (@(posedge clk) disable iff (rst)
    lit_count <= CW'(MAX_BLOCK))
    else $error("literal count overflow");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(pc))
    else $error("sequencer moved while stalled");

endmodule

@@ sim/rle_encoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_encoder_checker
// Watches the byte and word channels of the run/literal encoder. Every
// accepted byte runs through a cycle-free model of the encoder, and the words
// it causes are queued. Every accepted word is compared field by field with
// the oldest queued word. Hands the failure count and the number of words
// still due to the testbench top.
// ----------------------------------------------------------------------------
module rle_encoder_checker
  import rle_pkg::*;
#(
  parameter int unsigned MAX_BLOCK = 127,
  parameter int unsigned OUT_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  input  logic        word_valid,
  input  logic        word_ready,
  input  logic [31:0] out_word,
  input  logic [2:0]  out_count,
  input  logic        burst_last,
  input  logic        stream_end,
  output int          fail_count,
  output int          due_count
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
    logic        send;
  } enc_word_t;

  logic [7:0]  lit_mem [MAX_BLOCK];
  int unsigned lit_cnt;
  int unsigned run_cnt;
  int unsigned warm;
  logic [7:0]  run_val;
  logic [7:0]  burst_q [$];
  enc_word_t   words_due [$];

  task automatic clear_encoder();
    lit_cnt = 0;
    run_cnt = 0;
    run_val = '0;
    warm    = WARMUP_INIT;
  endtask

  task automatic flush_run();
    if (run_cnt != 0) begin
      burst_q.push_back(RUN_FLAG | 8'(run_cnt));
      burst_q.push_back(run_val);
      run_cnt = 0;
    end
  endtask

  task automatic flush_lits();
    if (lit_cnt != 0) begin
      burst_q.push_back(8'(lit_cnt));
      for (int unsigned i = 0; i < lit_cnt; i++) burst_q.push_back(lit_mem[i]);
      lit_cnt = 0;
    end
  endtask

  task automatic store_lit(input logic [7:0] b);
    if (lit_cnt >= MAX_BLOCK) flush_lits();
    lit_mem[lit_cnt] = b;
    lit_cnt++;
  endtask

  task automatic pack_burst(input logic fin);
    enc_word_t   w;
    int unsigned pos;
    int unsigned n;
    pos = 0;
    while (pos < burst_q.size()) begin
      n = burst_q.size() - pos;
      if (n > OUT_BYTES) n = OUT_BYTES;
      w = '0;
      for (int unsigned j = 0; j < n; j++) w.word[8*j +: 8] = burst_q[pos+j];
      pos += n;
      w.count = 3'(n);
      w.last  = (pos >= burst_q.size());
      w.send  = w.last && fin;
      words_due.push_back(w);
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    burst_q.delete();
    if (warm != 0) begin
      store_lit(b);
      warm--;
    end else if (lit_cnt != 0) begin
      if (lit_cnt >= 2 && b == lit_mem[lit_cnt-1] && b == lit_mem[lit_cnt-2]) begin
        // last two literals join this byte as a run of three
        lit_cnt -= 2;
        flush_lits();
        run_val = b;
        run_cnt = RUN_START;
      end else begin
        store_lit(b);
      end
    end else if (b == run_val && run_cnt < MAX_BLOCK) begin
      run_cnt++;
    end else begin
      flush_run();
      store_lit(b);
    end
    if (fin) begin
      flush_run();
      flush_lits();
      clear_encoder();
    end
    pack_burst(fin);
  endtask

  task automatic check_word();
    enc_word_t due;
    if (words_due.size() == 0) begin
      $error("word with no transaction due: out_word %h out_count %0d", out_word, out_count);
      fail_count++;
    end else begin
      due = words_due.pop_front();
      if (out_word !== due.word) begin
        $error("out_word mismatch: expected %h, actual %h", due.word, out_word);
        fail_count++;
      end
      if (out_count !== due.count) begin
        $error("out_count mismatch: expected %0d, actual %0d", due.count, out_count);
        fail_count++;
      end
      if (burst_last !== due.last) begin
        $error("burst_last mismatch: expected %0b, actual %0b", due.last, burst_last);
        fail_count++;
      end
      if (stream_end !== due.send) begin
        $error("stream_end mismatch: expected %0b, actual %0b", due.send, stream_end);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_encoder();
      words_due.delete();
      fail_count = 0;
    end else begin
      if (word_valid && word_ready) check_word();
      if (byte_valid && byte_ready) encode_byte(data_byte, final_byte);
    end
    due_count = words_due.size();
  end

endmodule

@@ sim/tb_rle_run_literal_encoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rle_run_literal_encoder_unit
// Drives sections of raw bytes into the run/literal encoder: a short directed
// set of corner sections, one section with a full run and a full literal
// store, then random sections of runs, literals and noise. Both channels idle
// at random. A checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_rle_run_literal_encoder_unit;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } raw_byte_t;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_ready;
  logic [7:0]  data_byte;
  logic        final_byte;
  logic        word_valid;
  logic        word_ready;
  logic [31:0] out_word;
  logic [2:0]  out_count;
  logic        burst_last;
  logic        stream_end;
  int          fail_count;
  int          due_count;

  raw_byte_t   stim_q [$];
  logic [7:0]  last_data;
  logic        src_quiet;
  logic        sink_quiet;
  int          directed_n;

  rle_run_literal_encoder_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .out_word   (out_word),
    .out_count  (out_count),
    .burst_last (burst_last),
    .stream_end (stream_end)
  );

  rle_encoder_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .out_word   (out_word),
    .out_count  (out_count),
    .burst_last (burst_last),
    .stream_end (stream_end),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_byte(input logic [7:0] d, input logic f);
    raw_byte_t item;
    item.data = d;
    item.fin  = f;
    stim_q.push_back(item);
    last_data = d;
  endtask

  task automatic close_section();
    raw_byte_t item;
    item = stim_q.pop_back();
    item.fin = 1'b1;
    stim_q.push_back(item);
  endtask

  task automatic add_run(input logic [7:0] b, input int len);
    repeat (len) push_byte(b, 1'b0);
  endtask

  // no byte equals its neighbor, so nothing turns into a run
  task automatic add_literals(input int len);
    logic [7:0] b;
    repeat (len) begin
      do b = 8'($urandom_range(0, 255)); while (b == last_data);
      push_byte(b, 1'b0);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (due_count != 0);
    @(posedge clk);
  endtask

  task automatic send_byte(input raw_byte_t item);
    int g;
    g = pick_gap();
    if (g != 0 && !src_quiet) begin
      byte_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= item.data;
    final_byte <= item.fin;
    do @(negedge clk); while (!byte_ready);
    @(posedge clk);
  endtask

  initial begin : sink
    int n;
    sink_quiet = 1'b0;
    word_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) sink_quiet = ~sink_quiet;
      n = pick_gap();
      if (n != 0 && !sink_quiet) begin
        word_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      word_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(negedge clk);
      if (rst || (byte_valid && byte_ready) || (word_valid && word_ready)) idle = 0;
      else idle++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int total;
    int nseg;
    int r;
    last_data = '0;
    src_quiet = 1'b0;

    // final byte alone, during warmup
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    // run straight out of warmup, ended by the final byte
    add_run(8'h41, 3);
    close_section();
    // literal flushed by a match, run broken by a different byte
    push_byte(8'h10, 1'b0);
    add_run(8'h20, 4);
    push_byte(8'h30, 1'b0);
    push_byte(8'h31, 1'b1);
    add_run(8'h55, 5);
    close_section();
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7f, 1'b1);
    add_run(8'haa, 3);
    push_byte(8'hbb, 1'b1);
    directed_n = stim_q.size();

    // full run, then a full literal store
    add_run(8'h5a, 129);
    add_literals(128);
    close_section();

    total = stim_q.size() + RANDOM_ITEMS;
    while (stim_q.size() < total) begin
      nseg = $urandom_range(1, 6);
      repeat (nseg) begin
        r = $urandom_range(0, 99);
        if (r < 3) add_run(8'($urandom_range(0, 255)), $urandom_range(120, 131));
        else if (r < 6) add_literals($urandom_range(120, 131));
        else if (r < 50) add_run(8'($urandom_range(0, 255)), $urandom_range(1, 12));
        else if (r < 88) add_literals($urandom_range(1, 10));
        else begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 2))
              0:       push_byte(8'h00, $urandom_range(0, 9) == 0);
              1:       push_byte(8'hff, $urandom_range(0, 9) == 0);
              default: push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            endcase
          end
        end
      end
      close_section();
    end

    rst        <= 1'b1;
    byte_valid <= 1'b0;
    data_byte  <= '0;
    final_byte <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < stim_q.size(); i++) begin
      if ($urandom_range(0, 15) == 0) src_quiet = ~src_quiet;
      send_byte(stim_q[i]);
      if (i == directed_n - 1 || i == stim_q.size() / 2) begin
        byte_valid <= 1'b0;
        wait_drained();
      end
    end
    byte_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ rle_run_literal_encoder_unit.f @@
src/rle_pkg.sv
src/rle_ram.sv
src/rle_run_literal_encoder_unit.sv
sim/rle_encoder_checker.sv
sim/tb_rle_run_literal_encoder_unit.sv
